### rtl/pbl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbl_pkg
// Shared types and constants of the LRU page-buffer directory.
// ----------------------------------------------------------------------------
package pbl_pkg;

  localparam int BUFFER_SLOTS = 32;
  localparam int POS_W        = $clog2(BUFFER_SLOTS);
  localparam int CNT_W        = $clog2(BUFFER_SLOTS + 1);

  localparam logic [2:0] KIND_FETCH  = 3'd0;
  localparam logic [2:0] KIND_CREATE = 3'd1;
  localparam logic [2:0] KIND_MARK   = 3'd2;
  localparam logic [2:0] KIND_FLUSHP = 3'd3;
  localparam logic [2:0] KIND_FLUSHF = 3'd4;
  localparam logic [2:0] KIND_FLUSHA = 3'd5;

  localparam logic ACT_DONE = 1'b0;
  localparam logic ACT_WB   = 1'b1;

  typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_EXEC} state_t;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    pos_t        slot;
    logic [7:0]  file;
    logic [23:0] page;
    logic        dirty;
  } entry_t;

  typedef struct packed {
    logic        move;
    pos_t        src;
    pos_t        dst;
    entry_t      ins;
    logic        dset;
    logic        dclr;
    pos_t        dpos;
    logic [7:0]  key_file;
    logic [23:0] key_page;
    cnt_t        busy;
  } cell_ctl_t;

  typedef struct packed {
    logic        action;
    logic [4:0]  slot;
    logic [7:0]  file;
    logic [23:0] page;
    logic        hit;
    logic        needs_read;
    logic        not_resident;
    logic        last;
  } res_t;

  function automatic logic [4:0] slot_field(pos_t s);
    logic [31:0] t;
    t = 32'(s);
    return t[4:0];
  endfunction

endpackage
`default_nettype wire

### rtl/pbl_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbl_in_if / pbl_out_if
// Request and result channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pbl_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  file_id;
  logic [23:0] page_no;
  modport source(output valid, kind, file_id, page_no, input ready);
  modport sink(input valid, kind, file_id, page_no, output ready);
endinterface

interface pbl_out_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [4:0]  slot;
  logic [7:0]  out_file_id;
  logic [23:0] out_page_no;
  logic        hit;
  logic        needs_read;
  logic        not_resident;
  logic        last;
  modport source(output valid, action, slot, out_file_id, out_page_no, hit,
                 needs_read, not_resident, last, input ready);
  modport sink(input valid, action, slot, out_file_id, out_page_no, hit,
               needs_read, not_resident, last, output ready);
endinterface
`default_nettype wire

### rtl/pbl_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbl_cell
// One position of the unified recency/free list: holds a slot and its key.
// ----------------------------------------------------------------------------
module pbl_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pbl_pkg::pos_t     idx,
  input  wire pbl_pkg::cell_ctl_t ctl,
  input  wire pbl_pkg::entry_t   left,
  input  wire pbl_pkg::entry_t   right,
  output pbl_pkg::entry_t        ent,
  output logic                   match
);
  import pbl_pkg::*;

  pos_t        slot_r, slot_nxt;
  logic        dirty_r, dirty_nxt;
  logic [7:0]  file_r, file_nxt;
  logic [23:0] page_r, page_nxt;
  entry_t      take;

  assign ent = '{slot: slot_r, file: file_r, page: page_r, dirty: dirty_r};

  assign match = (CNT_W'(idx) < ctl.busy) && (file_r == ctl.key_file) &&
                 (page_r == ctl.key_page);

  always_comb begin
    take = ent;
    if (ctl.move) begin
      if (idx == ctl.dst) begin
        take = ctl.ins;
      end else if (ctl.src > ctl.dst && idx > ctl.dst && idx <= ctl.src) begin
        take = left;
      end else if (ctl.src < ctl.dst && idx >= ctl.src && idx < ctl.dst) begin
        take = right;
      end
    end else if (idx == ctl.dpos) begin
      if (ctl.dset) take.dirty = 1'b1;
      if (ctl.dclr) take.dirty = 1'b0;
    end
    slot_nxt  = take.slot;
    file_nxt  = take.file;
    page_nxt  = take.page;
    dirty_nxt = take.dirty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= idx;
      dirty_r <= 1'b0;
    end else begin
      slot_r  <= slot_nxt;
      dirty_r <= dirty_nxt;
    end
  end

  // key travels with the slot, no reset needed
  always_ff @(posedge clk) begin
    file_r <= file_nxt;
    page_r <= page_nxt;
  end

endmodule
`default_nettype wire

### rtl/page_buffer_pool_lru.sv
`default_nettype none
// ----------------------------------------------------------------------------
// page_buffer_pool_lru
// LRU page-buffer directory over a chain of list cells.
// ----------------------------------------------------------------------------
// The directory is one list of BUFFER_SLOTS cells: the first busy-count cells
// are the resident slots, most recent first, and the rest are the free queue,
// front first. Every cell carries its slot number, key and dirty flag, and all
// list updates are one move of a cell to another position, with the cells in
// between shifting one step toward their neighbor. A request is taken only
// when the block is idle. Every request passes the accept, associative lookup
// and update states, and the update state repeats for each write-back word.
// Flush file and flush all also step once through each resident slot. The
// single output register sets the pace whenever the sink stalls: a step that
// emits a word waits until that register is free.
// ----------------------------------------------------------------------------
module page_buffer_pool_lru (
  input  wire logic clk,
  input  wire logic rst_n,
  pbl_in_if.sink    in_ch,
  pbl_out_if.source out_ch
);
  import pbl_pkg::*;

  localparam pos_t LASTP = POS_W'(BUFFER_SLOTS - 1);
  localparam cnt_t FULL  = CNT_W'(BUFFER_SLOTS);

  state_t      state_r, state_nxt;
  logic [2:0]  kind_r;
  logic [7:0]  file_r;
  logic [23:0] page_r;
  logic        hit_r, hit_nxt;
  pos_t        hpos_r, hpos_nxt;
  cnt_t        cur_r, cur_nxt;
  cnt_t        busy_r, busy_nxt;
  logic        ov_r;
  res_t        res_r;

  cell_ctl_t   ctl;
  entry_t      cells [BUFFER_SLOTS];
  logic [BUFFER_SLOTS-1:0] match;
  pos_t        rd_pos;
  entry_t      rd;
  logic        can_emit, emit, done;
  res_t        res;
  pos_t        busy_m1;

  // ---- cell chain -----------------------------------------------------------
  for (genvar i = 0; i < BUFFER_SLOTS; i++) begin : g_cell
    pbl_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .idx   (POS_W'(i)),
      .ctl   (ctl),
      .left  (cells[(i == 0) ? 0 : i - 1]),
      .right (cells[(i == BUFFER_SLOTS - 1) ? i : i + 1]),
      .ent   (cells[i]),
      .match (match[i])
    );
  end

  assign rd       = cells[rd_pos];
  assign can_emit = !ov_r || out_ch.ready;
  assign busy_m1  = POS_W'(busy_r - CNT_W'(1));

  // ---- lookup: first resident match in recency order ------------------------
  always_comb begin
    hit_nxt  = 1'b0;
    hpos_nxt = '0;
    for (int i = BUFFER_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_nxt  = 1'b1;
        hpos_nxt = POS_W'(i);
      end
    end
  end

  // ---- update and result per step -------------------------------------------
  always_comb begin
    ctl          = '0;
    ctl.key_file = file_r;
    ctl.key_page = page_r;
    ctl.busy     = busy_r;
    rd_pos       = hpos_r;
    emit         = 1'b0;
    done         = 1'b0;
    res          = '0;
    res.last     = 1'b1;
    busy_nxt     = busy_r;
    cur_nxt      = cur_r;
    if (state_r == ST_LOOK) begin
      cur_nxt = '0;
    end else if (state_r == ST_EXEC) begin
      unique case (kind_r)
        KIND_FETCH, KIND_CREATE: begin
          if (hit_r) begin
            rd_pos = hpos_r;
          end else if (busy_r != FULL) begin
            rd_pos = busy_r[POS_W-1:0];
          end else begin
            rd_pos = LASTP;
          end
          if (can_emit) begin
            emit = 1'b1;
            if (!hit_r && busy_r == FULL && rd.dirty) begin
              // evict a dirty victim: write it back first
              res      = '{ACT_WB, slot_field(rd.slot), rd.file, rd.page,
                           1'b0, 1'b0, 1'b0, 1'b0};
              ctl.dclr = 1'b1;
              ctl.dpos = LASTP;
            end else begin
              done     = 1'b1;
              ctl.move = 1'b1;
              ctl.src  = rd_pos;
              ctl.dst  = '0;
              ctl.ins  = '{slot: rd.slot, file: file_r, page: page_r,
                           dirty: (kind_r == KIND_CREATE) || (hit_r && rd.dirty)};
              res.slot = slot_field(rd.slot);
              res.file = file_r;
              res.page = page_r;
              res.hit  = hit_r;
              res.needs_read = !hit_r && (kind_r == KIND_FETCH);
              if (!hit_r && busy_r != FULL) busy_nxt = busy_r + CNT_W'(1);
            end
          end
        end
        KIND_MARK, KIND_FLUSHP: begin
          rd_pos = hpos_r;
          if (can_emit) begin
            emit = 1'b1;
            if (!hit_r) begin
              done             = 1'b1;
              res.file         = file_r;
              res.page         = page_r;
              res.not_resident = 1'b1;
            end else if (kind_r == KIND_FLUSHP && rd.dirty) begin
              res      = '{ACT_WB, slot_field(rd.slot), rd.file, rd.page,
                           1'b0, 1'b0, 1'b0, 1'b0};
              ctl.dclr = 1'b1;
              ctl.dpos = hpos_r;
            end else begin
              done     = 1'b1;
              res.slot = slot_field(rd.slot);
              res.file = file_r;
              res.page = page_r;
              if (kind_r == KIND_MARK) begin
                ctl.dset = 1'b1;
                ctl.dpos = hpos_r;
              end else begin
                // slot goes to the front of the free queue
                ctl.move = 1'b1;
                ctl.src  = hpos_r;
                ctl.dst  = busy_m1;
                ctl.ins  = rd;
                busy_nxt = busy_r - CNT_W'(1);
              end
            end
          end
        end
        KIND_FLUSHF: begin
          rd_pos = cur_r[POS_W-1:0];
          if (cur_r >= busy_r) begin
            if (can_emit) begin
              emit     = 1'b1;
              done     = 1'b1;
              res.file = file_r;
            end
          end else if (rd.file == file_r) begin
            if (rd.dirty) begin
              if (can_emit) begin
                emit     = 1'b1;
                res      = '{ACT_WB, slot_field(rd.slot), rd.file, rd.page,
                             1'b0, 1'b0, 1'b0, 1'b0};
                ctl.dclr = 1'b1;
                ctl.dpos = rd_pos;
              end
            end else begin
              // free it; the next candidate shifts into this position
              ctl.move = 1'b1;
              ctl.src  = rd_pos;
              ctl.dst  = busy_m1;
              ctl.ins  = rd;
              busy_nxt = busy_r - CNT_W'(1);
            end
          end else begin
            cur_nxt = cur_r + CNT_W'(1);
          end
        end
        KIND_FLUSHA: begin
          rd_pos = '0;
          if (busy_r == '0) begin
            if (can_emit) begin
              emit = 1'b1;
              done = 1'b1;
            end
          end else if (rd.dirty) begin
            if (can_emit) begin
              emit     = 1'b1;
              res      = '{ACT_WB, slot_field(rd.slot), rd.file, rd.page,
                           1'b0, 1'b0, 1'b0, 1'b0};
              ctl.dclr = 1'b1;
              ctl.dpos = '0;
            end
          end else begin
            // rotate: most recent goes to the back of the free queue
            ctl.move = 1'b1;
            ctl.src  = '0;
            ctl.dst  = LASTP;
            ctl.ins  = rd;
            busy_nxt = busy_r - CNT_W'(1);
          end
        end
        default: begin
          if (can_emit) begin
            emit = 1'b1;
            done = 1'b1;
          end
        end
      endcase
    end
  end

  // ---- next state -----------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = ST_LOOK;
      ST_LOOK: state_nxt = ST_EXEC;
      ST_EXEC: if (done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---- outputs --------------------------------------------------------------
  always_comb begin
    in_ch.ready         = (state_r == ST_IDLE);
    out_ch.valid        = ov_r;
    out_ch.action       = res_r.action;
    out_ch.slot         = res_r.slot;
    out_ch.out_file_id  = res_r.file;
    out_ch.out_page_no  = res_r.page;
    out_ch.hit          = res_r.hit;
    out_ch.needs_read   = res_r.needs_read;
    out_ch.not_resident = res_r.not_resident;
    out_ch.last         = res_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      if (emit)              ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
  end

  // hold request and lookup result; payload needs no reset
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_ch.valid) begin
      kind_r <= in_ch.kind;
      file_r <= in_ch.file_id;
      page_r <= in_ch.page_no;
    end
    if (state_r == ST_LOOK) begin
      hit_r  <= hit_nxt;
      hpos_r <= hpos_nxt;
    end
    cur_r <= cur_nxt;
    if (emit) res_r <= res;
  end

endmodule
`default_nettype wire

### verif/page_buffer_pool_lru_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// page_buffer_pool_lru_tb
// Self-checking bench for the LRU page-buffer directory.
// ----------------------------------------------------------------------------
// A queue of requests feeds a burst-shaped driver. A monitor on the request
// channel runs every accepted word through a directory predictor held in the
// bench, and a result monitor checks each result word against the oldest
// prediction. The receiver stalls on a changing pattern, with one long
// hold-off that backs the block up. The sender pauses between phases until
// every prediction has been matched.
// ----------------------------------------------------------------------------
module page_buffer_pool_lru_tb;
  import pbl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_STALL  = 300;
  localparam int KEY_POOL    = 40;

  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  file;
    logic [23:0] page;
  } request_t;

  logic clk;
  logic rst_n;

  pbl_in_if  in_ch ();
  pbl_out_if out_ch ();

  page_buffer_pool_lru dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // Directory mirror: resident slots most recent first, free slots front first.
  logic        dir_valid [BUFFER_SLOTS];
  logic        dir_dirty [BUFFER_SLOTS];
  logic [7:0]  dir_file  [BUFFER_SLOTS];
  logic [23:0] dir_page  [BUFFER_SLOTS];
  int          lru_q  [$];
  int          free_q [$];

  request_t request_q [$];
  res_t     pending_results [$];

  int  fail_count;
  int  cycle_count;
  int  items_sent;
  int  results_seen;
  int  writebacks_seen;
  int  hits_seen;
  bit  in_taken;
  bit  hold_sender;
  bit  long_stall_req;
  bit  long_stall_done;
  int  long_stall_left;
  int  burst_left;
  int  gap_left;
  int  ready_mode;
  logic [7:0]  pool_file [KEY_POOL];
  logic [23:0] pool_page [KEY_POOL];
  logic [7:0]  hot_files [4];

  function automatic void expect_word(logic act, int s, logic [7:0] f, logic [23:0] p,
                                      logic h, logic nr, logic nres, logic lst);
    res_t r;
    r.action       = act;
    r.slot         = 5'(s);
    r.file         = f;
    r.page         = p;
    r.hit          = h;
    r.needs_read   = nr;
    r.not_resident = nres;
    r.last         = lst;
    if (act == ACT_WB) writebacks_seen++;
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Emit a write-back if the slot holds unsaved data, and clean it.
  function automatic void flush_slot(int s);
    if (dir_dirty[s]) begin
      dir_dirty[s] = 1'b0;
      expect_word(ACT_WB, s, dir_file[s], dir_page[s], 1'b0, 1'b0, 1'b0, 1'b0);
    end
  endfunction

  function automatic int lookup_key(logic [7:0] f, logic [23:0] p);
    for (int i = 0; i < lru_q.size(); i++)
      if (dir_valid[lru_q[i]] && dir_file[lru_q[i]] == f && dir_page[lru_q[i]] == p)
        return i;
    return -1;
  endfunction

  function automatic void predict_directory(logic [2:0] k, logic [7:0] f, logic [23:0] p);
    int pos;
    int s;
    int walk [$];
    case (k)
      KIND_FETCH, KIND_CREATE: begin
        pos = lookup_key(f, p);
        if (pos >= 0) begin
          // Hit: promote to most recent.
          s = lru_q[pos];
          lru_q.delete(pos);
          lru_q.push_front(s);
          if (k == KIND_CREATE) dir_dirty[s] = 1'b1;
          hits_seen++;
          expect_word(ACT_DONE, s, f, p, 1'b1, 1'b0, 1'b0, 1'b1);
        end else begin
          if (lru_q.size() < BUFFER_SLOTS) begin
            s = free_q.pop_front();
          end else begin
            s = lru_q.pop_back();
            flush_slot(s);
          end
          lru_q.push_front(s);
          dir_valid[s] = 1'b1;
          dir_file[s]  = f;
          dir_page[s]  = p;
          dir_dirty[s] = (k == KIND_CREATE);
          expect_word(ACT_DONE, s, f, p, 1'b0, k == KIND_FETCH, 1'b0, 1'b1);
        end
      end
      KIND_MARK, KIND_FLUSHP: begin
        pos = lookup_key(f, p);
        if (pos < 0) begin
          expect_word(ACT_DONE, 0, f, p, 1'b0, 1'b0, 1'b1, 1'b1);
        end else begin
          s = lru_q[pos];
          if (k == KIND_MARK) begin
            dir_dirty[s] = 1'b1;
          end else begin
            flush_slot(s);
            free_q.push_front(s);
            lru_q.delete(pos);
            dir_valid[s] = 1'b0;
          end
          expect_word(ACT_DONE, s, f, p, 1'b0, 1'b0, 1'b0, 1'b1);
        end
      end
      KIND_FLUSHF, KIND_FLUSHA: begin
        walk = lru_q;
        lru_q.delete();
        foreach (walk[i]) begin
          s = walk[i];
          if (k == KIND_FLUSHF && dir_file[s] != f) begin
            lru_q.insert(lru_q.size(), s);
          end else begin
            flush_slot(s);
            dir_valid[s] = 1'b0;
            // File-scoped frees go to the front, flush-all to the back.
            if (k == KIND_FLUSHF) free_q.push_front(s);
            else free_q.insert(free_q.size(), s);
          end
        end
        expect_word(ACT_DONE, 0, (k == KIND_FLUSHF) ? f : 8'd0, 24'd0,
                    1'b0, 1'b0, 1'b0, 1'b1);
      end
      default: expect_word(ACT_DONE, 0, 8'd0, 24'd0, 1'b0, 1'b0, 1'b0, 1'b1);
    endcase
  endfunction

  function automatic void queue_request(logic [2:0] k, logic [7:0] f, logic [23:0] p);
    request_t r;
    r.kind = k;
    r.file = f;
    r.page = p;
    request_q.insert(request_q.size(), r);
  endfunction

  // Mostly reuse keys so hits, evictions and flushes find residents.
  function automatic void queue_random();
    int w;
    int idx;
    logic [2:0]  k;
    logic [7:0]  f;
    logic [23:0] p;
    w = $urandom_range(0, 99);
    if (w < 35)      k = KIND_FETCH;
    else if (w < 60) k = KIND_CREATE;
    else if (w < 75) k = KIND_MARK;
    else if (w < 87) k = KIND_FLUSHP;
    else if (w < 94) k = KIND_FLUSHF;
    else if (w < 97) k = KIND_FLUSHA;
    else             k = 3'($urandom_range(6, 7));
    if ($urandom_range(0, 9) < 8) begin
      idx = $urandom_range(0, KEY_POOL - 1);
      f = pool_file[idx];
      p = pool_page[idx];
    end else begin
      f = 8'($urandom);
      p = 24'($urandom);
    end
    if (k == KIND_FLUSHF && $urandom_range(0, 3) != 0) f = hot_files[$urandom_range(0, 3)];
    queue_request(k, f, p);
  endfunction

  // Request side: predict on every accepted word.
  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      items_sent++;
      predict_directory(in_ch.kind, in_ch.file_id, in_ch.page_no);
    end
  end

  // Driver: advance on falling edges, in bursts separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (hold_sender || request_q.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else begin
        request_t r;
        r = request_q.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.kind    <= r.kind;
        in_ch.file_id <= r.file;
        in_ch.page_no <= r.page;
        if (burst_left == 0) begin
          burst_left = $urandom_range(0, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Receiver: drop ready on a randomly chosen pattern, with one long hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (long_stall_req && !long_stall_done) begin
      long_stall_done = 1'b1;
      long_stall_left = LONG_STALL;
      out_ch.ready <= 1'b0;
    end else if (long_stall_left > 0) begin
      long_stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      if (cycle_count % 64 == 0) ready_mode = $urandom_range(0, 3);
      case (ready_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom);
        2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= cycle_count[0];
      endcase
    end
  end

  // Result monitor and watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_results.size());
      $display("tb: failure");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      res_t got;
      res_t want;
      got = '{out_ch.action, out_ch.slot, out_ch.out_file_id, out_ch.out_page_no,
              out_ch.hit, out_ch.needs_read, out_ch.not_resident, out_ch.last};
      results_seen++;
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t unexpected result word: expected none, actual %p", $time, got);
      end else begin
        want = pending_results.pop_front();
        if (got.action !== want.action || got.slot !== want.slot || got.file !== want.file ||
            got.page !== want.page || got.hit !== want.hit ||
            got.needs_read !== want.needs_read ||
            got.not_resident !== want.not_resident || got.last !== want.last) begin
          fail_count++;
          $display("%0t result mismatch: expected %p, actual %p", $time, want, got);
        end
      end
    end
  end

  task automatic wait_drained();
    while (request_q.size() != 0 || in_ch.valid || pending_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_FETCH;
    in_ch.file_id = '0;
    in_ch.page_no = '0;
    out_ch.ready = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    burst_left = 0;
    gap_left = 0;
    ready_mode = 0;
    hold_sender = 1'b0;
    long_stall_req = 1'b0;
    long_stall_done = 1'b0;
    long_stall_left = 0;
    for (int i = 0; i < BUFFER_SLOTS; i++) begin
      dir_valid[i] = 1'b0;
      dir_dirty[i] = 1'b0;
      dir_file[i]  = '0;
      dir_page[i]  = '0;
      free_q.insert(free_q.size(), i);
    end
    foreach (hot_files[i]) hot_files[i] = 8'($urandom);
    foreach (pool_file[i]) begin
      pool_file[i] = hot_files[$urandom_range(0, 3)];
      pool_page[i] = ($urandom_range(0, 1) == 0) ? 24'($urandom_range(0, 15)) : 24'($urandom);
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, every kind, absent keys, dirty and clean paths.
    queue_request(KIND_MARK,   8'h00, 24'h000000);
    queue_request(KIND_FLUSHP, 8'hFF, 24'hFFFFFF);
    queue_request(KIND_FETCH,  8'h00, 24'h000000);
    queue_request(KIND_FETCH,  8'h00, 24'h000000);
    queue_request(KIND_CREATE, 8'hFF, 24'hFFFFFF);
    queue_request(KIND_CREATE, 8'hFF, 24'hFFFFFF);
    queue_request(KIND_CREATE, 8'hA5, 24'h5A5A5A);
    queue_request(KIND_MARK,   8'h00, 24'h000000);
    queue_request(KIND_FLUSHP, 8'h00, 24'h000000);
    queue_request(KIND_FETCH,  8'h5A, 24'hA5A5A5);
    queue_request(KIND_FLUSHP, 8'h5A, 24'hA5A5A5);
    queue_request(KIND_FLUSHF, 8'hFF, 24'h000000);
    queue_request(KIND_FLUSHF, 8'h12, 24'h000000);
    queue_request(3'd6, 8'hFF, 24'hFFFFFF);
    queue_request(3'd7, 8'h00, 24'h000000);
    queue_request(KIND_CREATE, 8'h01, 24'h000001);
    queue_request(KIND_FETCH,  8'h02, 24'h800000);
    queue_request(KIND_FLUSHA, 8'h00, 24'h000000);
    queue_request(KIND_FLUSHA, 8'hFF, 24'hFFFFFF);
    wait_drained();

    // Fill past capacity with mostly dirty pages to force write-back evictions.
    hold_sender = 1'b1;
    for (int i = 0; i < BUFFER_SLOTS + 6; i++)
      queue_request(($urandom_range(0, 2) == 0) ? KIND_FETCH : KIND_CREATE,
                    8'(i), 24'($urandom));
    hold_sender = 1'b0;
    wait_drained();

    // Random phase with one long receiver hold-off while requests are still queued.
    for (int i = 0; i < 150; i++) queue_random();
    long_stall_req = 1'b1;
    wait_drained();

    for (int i = 0; i < 120; i++) queue_random();
    wait_drained();
    repeat (50) @(posedge clk);

    $display("covered %0d requests, %0d result words, %0d write-backs, %0d hits",
             items_sent, results_seen, writebacks_seen, hits_seen);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
rtl/pbl_pkg.sv
rtl/pbl_if.sv
rtl/pbl_cell.sv
rtl/page_buffer_pool_lru.sv
verif/page_buffer_pool_lru_tb.sv
